// ===== rtl/wbvr_pkg.sv =====
// Shared types and constants for the world-to-body velocity rotation block.
// Holds register indices, reset values, the phase scaling constants and the
// CORDIC arctangent table. No dependencies.
package wbvr_pkg;

   localparam int SPEED_W     = 15;
   localparam int YAW_W       = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int PHASE_W     = 32;

   typedef logic signed [SPEED_W-1:0] speed_type;
   typedef logic [CSR_INDEX_W-1:0]    csr_index_type;

   localparam csr_index_type CSR_WORLD_X  = 3'd0;
   localparam csr_index_type CSR_WORLD_Y  = 3'd1;
   localparam csr_index_type CSR_SPIN     = 3'd2;
   localparam csr_index_type CSR_RAMP     = 3'd3;
   localparam csr_index_type CSR_MOTION   = 3'd4;

   localparam speed_type WORLD_X_RESET = 15'sd100;
   localparam speed_type WORLD_Y_RESET = 15'sd0;
   localparam speed_type SPIN_RESET    = 15'sd30;
   localparam logic      RAMP_RESET    = 1'b1;
   localparam logic      MOTION_RESET  = 1'b0;

   localparam int SPEED_MAX = 16383;
   localparam int SPEED_MIN = -16384;

   // Centidegrees per full turn and half of it, for rounding.
   localparam logic [15:0] TURN_CDEG      = 16'd36000;
   localparam logic [15:0] HALF_TURN_CDEG = 16'd18000;

   // Reciprocal of a turn, scaled so that the product keeps 16 guard bits.
   localparam logic [32:0] PHASE_RECIP = 33'((64'd1 << 48) / 64'd36000);

   // CORDIC gain in Q2.30.
   localparam logic [63:0] K_Q30 = 64'd652032874;

   // Arctangent of 2^-i in units of 2^-32 turn.
   localparam logic [31:0] ATAN_TURN [32] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81,
      32'd41,        32'd20,        32'd10,        32'd5,
      32'd3,         32'd1,         32'd1,         32'd0
   };

endpackage

// ===== rtl/world_to_body_velocity_rotate_top.sv =====
// World-to-body velocity rotation, top level.
// Depends on wbvr_pkg for types, register indices and the CORDIC table.
//
// Each yaw word (centidegrees) rotates the configured world-frame velocity
// into the body frame and yields one result word carrying both body speeds,
// the spin speed and the ramp flag; while motion is disabled, accepted yaw
// words yield nothing. The block takes one word in every cycle unless the
// result output stalls it. A yaw word passes through the phase scaling
// stages, the pipelined CORDIC, which performs four micro-rotations per
// stage, and the multiplier and sum stages before the result register.
// Registers are to be written only while no word is in flight.
module world_to_body_velocity_rotate_top #(
   parameter int TRIG_FRAC_BITS = 15
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] yaw_cdeg
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [14:0] body_x_speed, [29:15] body_y_speed,
                                    // [44:30] spin_speed, [45] ramp_on, [47:46] zero
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_wr_index,
   input  logic [14:0] csr_wr_data
);

   localparam int ITER     = TRIG_FRAC_BITS + 1;
   localparam int CS       = (ITER + 3) / 4;
   localparam int ST_INIT  = 4;
   localparam int ST_MULT  = CS + 5;
   localparam int ST_SUM   = CS + 6;
   localparam int NV       = CS + 7;
   localparam int CW       = TRIG_FRAC_BITS + 3;
   localparam int PW       = TRIG_FRAC_BITS + 18;
   localparam int SW       = TRIG_FRAC_BITS + 19;

   localparam logic [63:0] KX_WIDE =
      ((wbvr_pkg::K_Q30 << 1) + (64'd1 << (30 - TRIG_FRAC_BITS))) >> (31 - TRIG_FRAC_BITS);
   localparam logic signed [CW-1:0] KX = $signed(CW'(KX_WIDE));

   localparam logic signed [SW-1:0] TRUNC_BIAS = SW'((64'sd1 <<< TRIG_FRAC_BITS) - 64'sd1);
   localparam logic signed [SW-1:0] ZERO_SUM   = SW'(0);
   localparam logic signed [SW-1:0] SAT_HI     = SW'(wbvr_pkg::SPEED_MAX);
   localparam logic signed [SW-1:0] SAT_LO     = SW'(wbvr_pkg::SPEED_MIN);

   // Configuration registers
   wbvr_pkg::speed_type wx_ff, wy_ff, spin_ff;
   logic                ramp_ff, motion_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wx_ff     <= wbvr_pkg::WORLD_X_RESET;
         wy_ff     <= wbvr_pkg::WORLD_Y_RESET;
         spin_ff   <= wbvr_pkg::SPIN_RESET;
         ramp_ff   <= wbvr_pkg::RAMP_RESET;
         motion_ff <= wbvr_pkg::MOTION_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_wr_index)
            wbvr_pkg::CSR_WORLD_X: begin
               wx_ff <= $signed(csr_wr_data);
            end
            wbvr_pkg::CSR_WORLD_Y: begin
               wy_ff <= $signed(csr_wr_data);
            end
            wbvr_pkg::CSR_SPIN: begin
               spin_ff <= $signed(csr_wr_data);
            end
            wbvr_pkg::CSR_RAMP: begin
               ramp_ff <= csr_wr_data[0];
            end
            wbvr_pkg::CSR_MOTION: begin
               motion_ff <= csr_wr_data[0];
            end
            default: begin
            end
         endcase
      end
   end

   // Pipeline occupancy and per-stage ready
   logic          vld_ff [0:NV-1];
   logic [NV:0]   rdy;
   logic          rsp_tvalid_ff;

   assign rdy[NV] = !rsp_tvalid_ff || rsp_tready;
   for (genvar i = 0; i < NV; i++) begin : g_rdy
      assign rdy[i] = !vld_ff[i] || rdy[i+1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0]     <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (rdy[0]) begin
            vld_ff[0] <= req_tvalid && motion_ff;
         end
         if (rdy[NV]) begin
            rsp_tvalid_ff <= vld_ff[NV-1];
         end
      end
   end

   for (genvar i = 1; i < NV; i++) begin : g_vld
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (rdy[i]) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   assign req_tready = rdy[0];

   // Phase scaling: phase = round(|yaw| * 2^32 / 36000)
   logic [15:0] mag0_in, mag0_ff, mag1_ff;
   logic        neg0_ff, neg1_ff, neg2_ff, neg3_ff;
   logic [48:0] prod1_in, prod1_ff;
   logic [31:0] est2_in, est2_ff;
   logic [48:0] chk2_in, chk2_ff;
   logic [47:0] num2_in, num2_ff;
   logic [31:0] phase3_in, phase3_ff;

   assign mag0_in   = req_tdata[15] ? (16'd0 - req_tdata) : req_tdata;
   assign prod1_in  = 49'(mag0_ff) * 49'(wbvr_pkg::PHASE_RECIP);
   assign est2_in   = prod1_ff[47:16];
   assign chk2_in   = 49'({1'b0, est2_in} + 33'd1) * 49'(wbvr_pkg::TURN_CDEG);
   assign num2_in   = {mag1_ff, 32'd0} + 48'(wbvr_pkg::HALF_TURN_CDEG);
   assign phase3_in = est2_ff + 32'({1'b0, num2_ff} >= chk2_ff);

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         mag0_ff <= mag0_in;
         neg0_ff <= req_tdata[15];
      end
      if (rdy[1]) begin
         prod1_ff <= prod1_in;
         mag1_ff  <= mag0_ff;
         neg1_ff  <= neg0_ff;
      end
      if (rdy[2]) begin
         est2_ff <= est2_in;
         chk2_ff <= chk2_in;
         num2_ff <= num2_in;
         neg2_ff <= neg1_ff;
      end
      if (rdy[3]) begin
         phase3_ff <= phase3_in;
         neg3_ff   <= neg2_ff;
      end
   end

   // Quadrant folding and CORDIC start values
   logic signed [CW-1:0] cx_ff [0:CS];
   logic signed [CW-1:0] cy_ff [0:CS];
   logic signed [31:0]   cz_ff [0:CS];
   logic                 cflip_ff [0:CS];
   logic [31:0]          ph4;
   logic                 flip4;

   assign ph4   = neg3_ff ? (32'd0 - phase3_ff) : phase3_ff;
   assign flip4 = ph4[31] ^ ph4[30];

   always_ff @(posedge clock) begin
      if (rdy[ST_INIT]) begin
         cx_ff[0]    <= KX;
         cy_ff[0]    <= '0;
         cz_ff[0]    <= $signed({ph4[31] ^ flip4, ph4[30:0]});
         cflip_ff[0] <= flip4;
      end
   end

   for (genvar j = 0; j < CS; j++) begin : g_cordic
      logic signed [CW-1:0] x_nx, y_nx;
      logic signed [31:0]   z_nx;

      always_comb begin
         logic signed [CW-1:0] dx, dy;
         dx   = '0;
         dy   = '0;
         x_nx = cx_ff[j];
         y_nx = cy_ff[j];
         z_nx = cz_ff[j];
         for (int k = 0; k < 4; k++) begin
            if (4 * j + k < ITER) begin
               dx = y_nx >>> (4 * j + k);
               dy = x_nx >>> (4 * j + k);
               if (!z_nx[31]) begin
                  x_nx = x_nx - dx;
                  y_nx = y_nx + dy;
                  z_nx = z_nx - $signed(wbvr_pkg::ATAN_TURN[5'(4 * j + k)]);
               end else begin
                  x_nx = x_nx + dx;
                  y_nx = y_nx - dy;
                  z_nx = z_nx + $signed(wbvr_pkg::ATAN_TURN[5'(4 * j + k)]);
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[ST_INIT + 1 + j]) begin
            cx_ff[j+1]    <= x_nx;
            cy_ff[j+1]    <= y_nx;
            cz_ff[j+1]    <= z_nx;
            cflip_ff[j+1] <= cflip_ff[j];
         end
      end
   end

   // Products, sums and scaling
   logic signed [PW-1:0] pxc_ff, pys_ff, pxs_ff, pyc_ff;
   logic                 mflip_ff;
   logic signed [SW-1:0] sx_in, sy_in, sx_ff, sy_ff;

   always_ff @(posedge clock) begin
      if (rdy[ST_MULT]) begin
         pxc_ff   <= PW'(wx_ff) * PW'(cx_ff[CS]);
         pys_ff   <= PW'(wy_ff) * PW'(cy_ff[CS]);
         pxs_ff   <= PW'(wx_ff) * PW'(cy_ff[CS]);
         pyc_ff   <= PW'(wy_ff) * PW'(cx_ff[CS]);
         mflip_ff <= cflip_ff[CS];
      end
   end

   // A half-turn fold negates sine and cosine, and so the whole sum.
   assign sx_in = mflip_ff ? (ZERO_SUM - SW'(pxc_ff) - SW'(pys_ff))
                           : (SW'(pxc_ff) + SW'(pys_ff));
   assign sy_in = mflip_ff ? (SW'(pxs_ff) - SW'(pyc_ff))
                           : (SW'(pyc_ff) - SW'(pxs_ff));

   always_ff @(posedge clock) begin
      if (rdy[ST_SUM]) begin
         sx_ff <= sx_in;
         sy_ff <= sy_in;
      end
   end

   function automatic wbvr_pkg::speed_type scale_speed(logic signed [SW-1:0] sum);
      logic signed [SW-1:0] biased;
      logic signed [SW-1:0] quot;
      biased = sum + (sum[SW-1] ? TRUNC_BIAS : ZERO_SUM);
      quot   = biased >>> TRIG_FRAC_BITS;
      priority if (quot > SAT_HI) begin
         return wbvr_pkg::speed_type'(SAT_HI);
      end else if (quot < SAT_LO) begin
         return wbvr_pkg::speed_type'(SAT_LO);
      end else begin
         return wbvr_pkg::speed_type'(quot);
      end
   endfunction

   // Result register
   wbvr_pkg::speed_type bx_out_ff, by_out_ff, spin_out_ff;
   logic                ramp_out_ff;

   always_ff @(posedge clock) begin
      if (rdy[NV]) begin
         bx_out_ff   <= scale_speed(sx_ff);
         by_out_ff   <= scale_speed(sy_ff);
         spin_out_ff <= spin_ff;
         ramp_out_ff <= ramp_ff;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {2'b00, ramp_out_ff, spin_out_ff, by_out_ff, bx_out_ff};

endmodule

// ===== rtl/wbvr_checker.sv =====
// Port-level checks for the world-to-body velocity rotation top level.
// Bound to world_to_body_velocity_rotate_top; needs no package.
module wbvr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata
);

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result word valid straight after reset");

   a_empty_accepts: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled while no result word is waiting");

   a_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result word withdrawn before it was taken");

   a_data_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result word changed while stalled");

endmodule

bind world_to_body_velocity_rotate_top wbvr_checker u_wbvr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
